// ===== design/mpir_pkg.sv =====
// shared types and constants of the median edge predictor image rebuild
package mpir_pkg;

    // field and register widths
    localparam int RES_W    = 15;
    localparam int PIX_W    = 8;
    localparam int REB_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CIDX_W   = 2;
    localparam int IMG_W_W  = 13;
    localparam int IMG_H_W  = 16;
    localparam int SHIFT_W  = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESIDUAL_SHIFT = 2'd2;

    // register reset values
    localparam logic [IMG_W_W-1:0] IMG_W_RST = 13'd640;
    localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd4;

    // output clamp limits
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // where a pixel sits in the image
    typedef struct packed {
        logic first_pix;
        logic top_row;
        logic left_col;
        logic last_img;
    } t_pos_flags;

endpackage

// ===== design/mpir_pos.sv =====
// column and row position tracking with wrap at the end of the image
module mpir_pos import mpir_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [IMG_W_W-1:0] i_width,
    input  logic [IMG_H_W-1:0] i_height,
    output logic [AW-1:0]      o_col,
    output t_pos_flags         o_flags
);

    localparam int LW = (AW > IMG_W_W) ? AW : IMG_W_W;

    logic [AW-1:0]      r_col, n_col;
    logic [IMG_H_W-1:0] r_row, n_row;
    logic [LW-1:0]      w_eff, wlast_raw, wlast, cap;
    logic [IMG_H_W-1:0] hlast;
    logic               last_col, last_row;

    always_comb begin
        w_eff     = (i_width == '0) ? LW'(1) : LW'(i_width);
        wlast_raw = w_eff - LW'(1);
        cap       = LW'(MAX_WIDTH - 1);
        wlast     = (wlast_raw > cap) ? cap : wlast_raw;
        hlast     = (i_height == '0) ? '0 : i_height - IMG_H_W'(1);
        last_col  = LW'(r_col) >= wlast;
        last_row  = r_row >= hlast;
        o_col     = last_col ? wlast[AW-1:0] : r_col;

        o_flags.left_col  = (o_col == '0);
        o_flags.top_row   = (r_row == '0);
        o_flags.first_pix = (o_col == '0) && (r_row == '0);
        o_flags.last_img  = last_col && last_row;

        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + IMG_H_W'(1);
        end else begin
            n_col = r_col + AW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/mpir_line.sv =====
// previous row store, one write and one registered read port
module mpir_line #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH),
    parameter int VB    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [VB-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [VB-1:0] o_rdata
);

    logic [VB-1:0] r_mem [DEPTH];
    logic [VB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mpir_predict.sv =====
// median edge prediction, residual removal, saturation and pixel clamp
module mpir_predict import mpir_pkg::*; #(
    parameter int VB = 16
) (
    input  t_pos_flags               i_flags,
    input  logic signed [RES_W-1:0]  i_residual,
    input  logic [SHIFT_W-1:0]       i_shift,
    input  logic signed [VB-1:0]     i_left,
    input  logic signed [VB-1:0]     i_above,
    input  logic signed [VB-1:0]     i_upleft,
    output logic signed [VB-1:0]     o_value,
    output logic [REB_W-1:0]         o_rebuilt,
    output logic                     o_sat,
    output logic [PIX_W-1:0]         o_pixel
);

    // wide enough for a + b - c and the shifted residual
    localparam int EW = (((VB + 2) > 20) ? (VB + 2) : 20) + 1;
    localparam longint HI_L = (longint'(1) <<< (VB - 1)) - longint'(1);
    localparam logic signed [EW-1:0] V_HI = EW'(HI_L);
    localparam logic signed [EW-1:0] V_LO = -V_HI - EW'(1);

    logic signed [EW-1:0] res_x, scaled, a, b, c, lo, hi, med, v_raw, v_sat;

    always_comb begin
        res_x  = EW'(i_residual);
        scaled = res_x <<< i_shift;
        a      = EW'(i_left);
        b      = EW'(i_above);
        c      = EW'(i_upleft);
        lo     = (a < b) ? a : b;
        hi     = (a < b) ? b : a;
        if (c >= hi) begin
            med = lo;
        end else if (c <= lo) begin
            med = hi;
        end else begin
            med = a + b - c;
        end

        if (i_flags.first_pix) begin
            v_raw = res_x;
        end else if (i_flags.top_row) begin
            v_raw = a - scaled;
        end else if (i_flags.left_col) begin
            v_raw = b - scaled;
        end else begin
            v_raw = med - scaled;
        end

        // reaching either limit counts as saturated
        o_sat = (v_raw >= V_HI) || (v_raw <= V_LO);
        if (v_raw >= V_HI) begin
            v_sat = V_HI;
        end else if (v_raw <= V_LO) begin
            v_sat = V_LO;
        end else begin
            v_sat = v_raw;
        end

        o_value   = v_sat[VB-1:0];
        o_rebuilt = v_sat[REB_W-1:0];
        if (v_sat < 0) begin
            o_pixel = PIX_MIN;
        end else if (v_sat > EW'(PIX_MAX)) begin
            o_pixel = PIX_MAX;
        end else begin
            o_pixel = v_sat[PIX_W-1:0];
        end
    end

endmodule

// ===== design/med_predictor_image_reconstruct.sv =====
// top level of the median edge predictor image rebuild
//
// channel   dir  handshake                    payload
// -------   ---  ---------------------------  ----------------------------------------
// residual  in   s_axis_tvalid/s_axis_tready  tdata: residual[14:0], zero pad to 16
// pixel     out  m_axis_tvalid/m_axis_tready  tdata: pixel, rebuilt_value; tuser: saturated;
//                                             tlast: last_of_image
// config    in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// one pixel per clock sustained while the output is not stalled; each transaction passes through
// the input stage, which holds the line store read, then the result register
// the line store read is issued as the residual is taken, with a forward of the value
// being written when a one pixel wide image reads the column just rebuilt
// synchronous active low reset clears positions, neighbours and valid flags; the line
// store is not cleared; a stalled output holds the input stage, the input stays open
// while the input stage is empty or moving on
module med_predictor_image_reconstruct import mpir_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int VALUE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // residual stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [14:0] residual, [15] zero
    // pixel stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [7:0] pixel, [23:8] rebuilt_value
    output logic                m_axis_tuser,   // [0] saturated
    output logic                m_axis_tlast,   // last pixel of the image
    // register writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int VB = VALUE_BITS;

    // configuration registers
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic [SHIFT_W-1:0] r_shift;
    logic [SHIFT_W-1:0] shift_eff;

    // input stage
    logic                    r_s1_valid;
    logic signed [RES_W-1:0] r_s1_res;
    t_pos_flags              r_s1_flags;
    logic [AW-1:0]           r_s1_col;
    logic                    r_s1_byp;
    logic [VB-1:0]           r_s1_byp_val;

    // neighbours of the next pixel
    logic signed [VB-1:0] r_left;
    logic signed [VB-1:0] r_upleft;

    // result register
    logic                r_out_valid;
    logic [PIX_W-1:0]    r_pixel;
    logic [REB_W-1:0]    r_rebuilt;
    logic                r_sat;
    logic                r_last;

    logic                accept, s1_adv;
    logic [AW-1:0]       pos_col;
    t_pos_flags          pos_flags;
    logic [VB-1:0]       mem_rdata;
    logic signed [VB-1:0] above;
    logic signed [VB-1:0] v_value;
    logic [REB_W-1:0]    v_rebuilt;
    logic                v_sat;
    logic [PIX_W-1:0]    v_pixel;

    // stage moves on when the result register is free or being emptied
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign shift_eff     = (r_shift > SHIFT_MAX) ? SHIFT_MAX : r_shift;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_RST;
            r_img_h <= IMG_H_RST;
            r_shift <= SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_img_w <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   r_img_h <= i_cfg_data[IMG_H_W-1:0];
                CFG_RESIDUAL_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    mpir_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_width   (r_img_w),
        .i_height  (r_img_h),
        .o_col     (pos_col),
        .o_flags   (pos_flags)
    );

    // previous row: written as a pixel leaves the input stage, read as the next is taken
    mpir_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .VB    (VB)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (v_value),
        .i_re    (accept),
        .i_raddr (pos_col),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // forward the value being written when the same column is read at this edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res     <= s_axis_tdata[RES_W-1:0];
            r_s1_flags   <= pos_flags;
            r_s1_col     <= pos_col;
            r_s1_byp     <= s1_adv && (r_s1_col == pos_col);
            r_s1_byp_val <= v_value;
        end
    end

    assign above = r_s1_byp ? r_s1_byp_val : mem_rdata;

    mpir_predict #(
        .VB (VB)
    ) u_predict (
        .i_flags    (r_s1_flags),
        .i_residual (r_s1_res),
        .i_shift    (shift_eff),
        .i_left     (r_left),
        .i_above    (above),
        .i_upleft   (r_upleft),
        .o_value    (v_value),
        .o_rebuilt  (v_rebuilt),
        .o_sat      (v_sat),
        .o_pixel    (v_pixel)
    );

    // left and upper-left follow each finished pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (s1_adv) begin
            r_left   <= v_value;
            r_upleft <= above;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_pixel   <= v_pixel;
            r_rebuilt <= v_rebuilt;
            r_sat     <= v_sat;
            r_last    <= r_s1_flags.last_img;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_rebuilt, r_pixel};
    assign m_axis_tuser  = r_sat;
    assign m_axis_tlast  = r_last;

endmodule

// ===== dv/pixel_rebuild_checker.sv =====
// pixel stream predictor and scoreboard for the median edge predictor image rebuild
module pixel_rebuild_checker import mpir_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [23:0]       m_axis_tdata,
    input  logic              m_axis_tuser,
    input  logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_pixels_seen,
    output int                o_saturated_seen,
    output int                o_image_ends,
    output int                o_row_pos
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam integer VAL_MAX = (1 <<< (REB_W - 1)) - 1;
    localparam integer VAL_MIN = -VAL_MAX - 1;

    typedef struct packed {
        logic [PIX_W-1:0]        pixel;
        logic signed [REB_W-1:0] rebuilt_value;
        logic                    saturated;
        logic                    last_of_image;
    } rebuilt_pixel_t;

    logic [IMG_W_W-1:0]      width_reg;
    logic [IMG_H_W-1:0]      height_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    logic signed [REB_W-1:0] prev_row [MAX_WIDTH];
    integer                  left_val;
    integer                  upper_left_val;
    int                      col_pos;
    int                      row_pos;
    rebuilt_pixel_t          expected_pixels [$];
    int                      residuals_in;
    int                      pixels_out;
    int                      mismatches;
    int                      saturated_seen;
    int                      image_ends;

    assign o_mismatches     = mismatches;
    assign o_pending        = residuals_in - pixels_out;
    assign o_pixels_seen    = pixels_out;
    assign o_saturated_seen = saturated_seen;
    assign o_image_ends     = image_ends;
    assign o_row_pos        = row_pos;

    // rebuilds one pixel from its residual and moves the position on
    function automatic rebuilt_pixel_t rebuild_pixel(input logic signed [RES_W-1:0] res);
        int             w;
        int             h;
        int             sh;
        int             col;
        bit             last_col;
        bit             last_row;
        integer         scaled;
        integer         above;
        integer         lo_n;
        integer         hi_n;
        integer         pred;
        integer         v;
        rebuilt_pixel_t px;
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h  = (height_reg == 0) ? 1 : int'(height_reg);
        sh = (shift_reg > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(shift_reg);
        // a shrunken size leaves the counters beyond the new last column or row
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        col      = last_col ? w - 1 : col_pos;
        scaled   = res;
        scaled   = scaled * (1 << sh);
        above    = prev_row[col];
        if (col == 0 && row_pos == 0) begin
            v = res;
        end else if (row_pos == 0) begin
            v = left_val - scaled;
        end else if (col == 0) begin
            v = above - scaled;
        end else begin
            lo_n = (left_val < above) ? left_val : above;
            hi_n = (left_val < above) ? above : left_val;
            if (upper_left_val >= hi_n) begin
                pred = lo_n;
            end else if (upper_left_val <= lo_n) begin
                pred = hi_n;
            end else begin
                pred = left_val + above - upper_left_val;
            end
            v = pred - scaled;
        end
        px.saturated = 1'b0;
        if (v >= VAL_MAX) begin
            px.saturated = 1'b1;
            v = VAL_MAX;
        end else if (v <= VAL_MIN) begin
            px.saturated = 1'b1;
            v = VAL_MIN;
        end
        upper_left_val = above;
        prev_row[col]  = v[REB_W-1:0];
        left_val       = v;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        if (v < 0) begin
            px.pixel = PIX_MIN;
        end else if (v > integer'(PIX_MAX)) begin
            px.pixel = PIX_MAX;
        end else begin
            px.pixel = v[PIX_W-1:0];
        end
        px.rebuilt_value = v[REB_W-1:0];
        px.last_of_image = last_col && last_row;
        return px;
    endfunction

    task automatic compare_field(input string field, input integer want, input integer got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rebuilt_pixel_t want;
        if (!i_rst_n) begin
            width_reg      = IMG_W_RST;
            height_reg     = IMG_H_RST;
            shift_reg      = SHIFT_RST;
            left_val       = 0;
            upper_left_val = 0;
            col_pos        = 0;
            row_pos        = 0;
            mismatches     = 0;
            saturated_seen = 0;
            image_ends     = 0;
            expected_pixels.delete();
            residuals_in  <= 0;
            pixels_out    <= 0;
        end else begin
            // output side first so a same-edge input never pairs with its own result
            if (m_axis_tvalid && m_axis_tready) begin
                pixels_out <= pixels_out + 1;
                if (m_axis_tuser) saturated_seen++;
                if (m_axis_tlast) image_ends++;
                if (expected_pixels.size() == 0) begin
                    $error("pixel transaction with no prediction waiting");
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("pixel", want.pixel, m_axis_tdata[PIX_W-1:0]);
                    compare_field("rebuilt_value", $signed(want.rebuilt_value),
                                  $signed(m_axis_tdata[PIX_W +: REB_W]));
                    compare_field("saturated", want.saturated, m_axis_tuser);
                    compare_field("last_of_image", want.last_of_image, m_axis_tlast);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg  = i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:   height_reg = i_cfg_data[IMG_H_W-1:0];
                    CFG_RESIDUAL_SHIFT: shift_reg  = i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                residuals_in <= residuals_in + 1;
                want = rebuild_pixel(s_axis_tdata[RES_W-1:0]);
                expected_pixels = {expected_pixels, want};
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// stimulus and verdict for the median edge predictor image rebuild
module testbench import mpir_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_WIDTH      = 4096;
    localparam int RANDOM_ITEMS   = 800;
    localparam int LONG_HOLD      = 60;
    localparam int TAIL_CYCLES    = 20;
    localparam int TIMEOUT_CYCLES = 500_000;

    // index with no register behind it, writes to it must be ignored
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    int                  mismatches;
    int                  pending;
    int                  pixels_seen;
    int                  saturated_seen;
    int                  image_ends;
    int                  row_now;

    // stimulus bookkeeping
    int                  items_sent  = 0;
    int                  reg_writes  = 0;
    int                  settings    = 0;
    logic [IMG_W_W-1:0]  cur_width   = IMG_W_RST;
    bit                  gaps_on     = 1'b1;
    int                  holds_asked = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    med_predictor_image_reconstruct #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (REB_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // watches all three channels, predicts every pixel and scores the results
    pixel_rebuild_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) pixel_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .m_axis_tlast     (m_axis_tlast),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_pixels_seen    (pixels_seen),
        .o_saturated_seen (saturated_seen),
        .o_image_ends     (image_ends),
        .o_row_pos        (row_now)
    );

    // idle length: drawn from one of three ranges, the shortest most often, the longest rarely
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // width the block really uses for a register value
    function automatic int eff_width(input logic [IMG_W_W-1:0] w);
        if (w == 0) return 1;
        return (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
    endfunction

    // one register write; valid drops for a cycle so back-to-back writes never
    // lower and raise it in the same step
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
        if (idx == CFG_IMAGE_WIDTH) cur_width = value[IMG_W_W-1:0];
    endtask

    // offers one residual, possibly after a random gap, and waits for the transaction
    task automatic feed(input int res);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, res[RES_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // sender pauses until every predicted pixel has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        settings++;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // receiver: random back-pressure plus the long hold-offs the stimulus asks for
    initial begin
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        int                 roll;
        int                 res;
        int                 burst;
        int                 random_start;
        logic [IMG_W_W-1:0] new_w;
        logic [IMG_H_W-1:0] new_h;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 frame with no shift: residual extremes drive the value onto the
        // top limit exactly, then past it, along the first row
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        write_reg(CFG_RESIDUAL_SHIFT, 16'd0);
        feed(16383); feed(-16384); feed(-16384); feed(0); feed(16383); feed(-1);
        drain();

        // zero width and height act as one, so every pixel is a first pixel and
        // the residual passes unshifted; a shift of seven acts as four
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        write_reg(CFG_RESIDUAL_SHIFT, 16'd7);
        feed(-16384); feed(16383); feed(0); feed(255); feed(256); feed(-1);
        drain();

        // width past the line store limit with spare data bits set; the largest
        // shift saturates low and then high
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        write_reg(CFG_RESIDUAL_SHIFT, 16'd4);
        feed(100); feed(16383); feed(-16384); feed(0);
        drain();

        // shrink the width below the column counter mid-row, and poke the
        // unused register index
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        write_reg(CFG_UNUSED, 16'hFFFF);
        feed(5); feed(7); feed(9);
        drain();

        // three rows of a taller image, then shrink the height below the row counter
        write_reg(CFG_IMAGE_HEIGHT, 16'd5);
        write_reg(CFG_RESIDUAL_SHIFT, 16'd0);
        feed(40); feed(-3); feed(10); feed(-20); feed(5); feed(5);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        feed(1); feed(-1);
        drain();

        // random settings, each followed by a burst of residuals
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      new_w = IMG_W_W'($urandom_range(1, 8));
            else if (roll < 80) new_w = IMG_W_W'($urandom_range(9, 40));
            else if (roll < 86) new_w = '0;
            else if (roll < 92) new_w = IMG_W_W'($urandom_range(MAX_WIDTH, (1 << IMG_W_W) - 1));
            else                new_w = IMG_W_W'($urandom_range(100, 700));
            // growing the width is only safe on the first row, where every column
            // of the new row gets written before the next row reads it
            if ($urandom_range(0, 1) == 1 &&
                (eff_width(new_w) <= eff_width(cur_width) || row_now == 0)) begin
                write_reg(CFG_IMAGE_WIDTH, {(CFG_W - IMG_W_W)'($urandom()), new_w});
            end

            roll = $urandom_range(0, 99);
            if (roll < 60)      new_h = IMG_H_W'($urandom_range(1, 6));
            else if (roll < 72) new_h = '0;
            else if (roll < 85) new_h = IMG_H_W'($urandom_range(7, 20));
            else if (roll < 92) new_h = '1;
            else                new_h = IMG_H_W'($urandom());
            if ($urandom_range(0, 1) == 1) write_reg(CFG_IMAGE_HEIGHT, new_h);

            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_RESIDUAL_SHIFT,
                          {(CFG_W - SHIFT_W)'($urandom()), SHIFT_W'($urandom_range(0, 7))});
            end
            if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom()));

            // some bursts run flat out; one at least meets a long hold-off at the
            // receiver so the block fills and stalls its input
            gaps_on = ($urandom_range(0, 4) != 0);
            if (holds_asked == 0 || $urandom_range(0, 9) == 0) begin
                gaps_on = 1'b0;
                holds_asked++;
            end

            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(6, 40);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    res = int'($urandom_range(0, 64)) - 32;
                end else if (roll < 80) begin
                    res = $urandom_range(0, (1 << RES_W) - 1);
                end else if (roll < 92) begin
                    res = int'($urandom_range(0, 4)) - 2;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       res = -16384;
                        1:       res = 16383;
                        2:       res = 0;
                        default: res = -1;
                    endcase
                end
                feed(res);
            end
            drain();
        end

        // let any stray late transaction show up before the verdict
        gaps_on = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d residuals under %0d settings with %0d register writes",
                 items_sent, settings, reg_writes);
        $display("checked %0d pixels, %0d of them saturated, %0d image ends",
                 pixels_seen, saturated_seen, image_ends);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $error("timeout with %0d pixels still outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
